// ===== rtl/msr_pkg.sv =====
// Shared types, codes and defaults for the mark-and-sweep reachability core.
package msr_pkg;

  localparam int HEAP_CHUNKS_DEF    = 16;
  localparam int ROOT_SLOTS_DEF     = 16;
  localparam int REFS_PER_CHUNK_DEF = 4;

  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_SET_ROOT = 2'd1;
  localparam logic [1:0] REQ_ADD_REF  = 2'd2;
  localparam logic [1:0] REQ_COLLECT  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_HEAP_FULL = 2'd1;
  localparam logic [1:0] ST_REFS_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] var_slot;
    logic [3:0] target_chunk;
    logic       root_is_null;
    logic [3:0] source_chunk;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] chunk_index;
    logic       reachable;
    logic       last;
  } rsp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

// ===== rtl/mark_sweep_reachability_core.sv =====
// Top level: request decode, heap graph memories, mark walk sequencer and result register.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes allocate, set-root, add-reference
//   and collect requests. rsp channel (rsp_valid/rsp_ready/rsp_item) returns results.
//   Allocate, set-root and add-reference each give one result with last set, in the
//   cycle after acceptance; these requests are taken back to back, one per cycle, while
//   each result is taken. Collect holds req_ready low while it works: it scans each
//   root slot in turn, then for each chunk reached pops it, reads its reference count
//   and reads each reference, pushing unmarked targets. On the empty stack it gives
//   one result per allocated chunk in index order (reachable flag, last on the
//   highest index). Collect with no chunks gives no result. The single read port of the
//   reference table and walk stack memory sets the walk time: one reference at a time.
//   One output register sits between the logic and rsp: a new request is taken in the
//   same cycle the previous result is taken. If the receiver stalls, the result holds
//   and req_ready (or the report sequence) waits.
//   Reset (rst, synchronous) empties the heap, clears all root slots and the stack.
//   Reference table and root target memories hold no reset value; an entry read before
//   its first write is never used.
module mark_sweep_reachability_core #(
  parameter int HEAP_CHUNKS    = msr_pkg::HEAP_CHUNKS_DEF,
  parameter int ROOT_SLOTS     = msr_pkg::ROOT_SLOTS_DEF,
  parameter int REFS_PER_CHUNK = msr_pkg::REFS_PER_CHUNK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  msr_pkg::req_item_t req_item,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output msr_pkg::rsp_item_t rsp_item
);

  localparam int IDX_W = $clog2(HEAP_CHUNKS);
  localparam int CNT_W = $clog2(HEAP_CHUNKS + 1);
  localparam int SL_W  = (ROOT_SLOTS > 1) ? $clog2(ROOT_SLOTS) : 1;
  localparam int RC_W  = $clog2(REFS_PER_CHUNK + 1);
  localparam int RA_W  = $clog2(HEAP_CHUNKS * REFS_PER_CHUNK);
  localparam int REF_DEPTH = HEAP_CHUNKS * REFS_PER_CHUNK;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RREAD  = 3'd1;
  localparam logic [2:0] S_RPUSH  = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_POPD   = 3'd4;
  localparam logic [2:0] S_EREAD  = 3'd5;
  localparam logic [2:0] S_EPUSH  = 3'd6;
  localparam logic [2:0] S_REPORT = 3'd7;

  logic [2:0]            state;
  logic [CNT_W-1:0]      chunk_count;
  logic [RC_W-1:0]       ref_count [HEAP_CHUNKS];
  logic [ROOT_SLOTS-1:0] root_has;
  logic [HEAP_CHUNKS-1:0] mark;
  logic [SL_W-1:0]       root_idx;
  logic                  root_has_q;
  logic [IDX_W-1:0]      cur;
  logic [RC_W-1:0]       ref_idx;
  logic [RC_W-1:0]       ref_n;
  logic [IDX_W-1:0]      rep_idx;
  logic                  out_valid;
  msr_pkg::rsp_item_t    out_item;

  logic [IDX_W-1:0] root_target [ROOT_SLOTS];
  logic [IDX_W-1:0] ref_table [REF_DEPTH];
  logic [IDX_W-1:0] root_rd;
  logic [IDX_W-1:0] ref_rd;

  // request decode
  logic               accept;
  logic               load_fire;
  logic               collect_go;
  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   src_idx;
  logic [SL_W-1:0]    slot_idx;
  logic               tgt_ok;
  logic               src_ok;
  logic [RC_W-1:0]    src_refs;
  logic               root_we;
  logic               ref_we;
  logic [RA_W-1:0]    ref_wa;
  logic [RA_W-1:0]    ref_ra;
  logic               alloc_do;
  logic               root_set;
  logic               root_clr;
  msr_pkg::rsp_item_t load_rsp;

  // walk / report
  msr_pkg::stack_ctrl_t stk_ctrl;
  logic [IDX_W-1:0]     push_cand;
  logic                 push_ok;
  logic [IDX_W-1:0]     pop_data;
  logic                 stk_empty;
  logic                 rep_emit;
  logic                 rep_last;

  assign req_ready = (state == S_IDLE) && (!out_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign load_fire = accept && (req_item.req_type != msr_pkg::REQ_COLLECT);
  assign collect_go = accept && (req_item.req_type == msr_pkg::REQ_COLLECT) &&
                      (chunk_count != '0);

  assign tgt_idx  = IDX_W'(req_item.target_chunk);
  assign src_idx  = IDX_W'(req_item.source_chunk);
  assign slot_idx = SL_W'(req_item.var_slot);
  assign tgt_ok   = 32'(req_item.target_chunk) < 32'(chunk_count);
  assign src_ok   = 32'(req_item.source_chunk) < 32'(chunk_count);
  assign src_refs = src_ok ? ref_count[src_idx] : '0;
  assign ref_wa   = RA_W'(32'(src_idx) * REFS_PER_CHUNK + 32'(src_refs));
  assign ref_ra   = RA_W'(32'(cur) * REFS_PER_CHUNK + 32'(ref_idx));

  always_comb begin
    load_rsp             = '0;
    load_rsp.last        = 1'b1;
    alloc_do             = 1'b0;
    root_set             = 1'b0;
    root_clr             = 1'b0;
    ref_we               = 1'b0;
    unique case (req_item.req_type)
      msr_pkg::REQ_ALLOC: begin
        if (32'(chunk_count) >= HEAP_CHUNKS) begin
          load_rsp.status = msr_pkg::ST_HEAP_FULL;
        end else begin
          alloc_do             = load_fire;
          load_rsp.chunk_index = 4'(chunk_count);
        end
      end
      msr_pkg::REQ_SET_ROOT: begin
        if (32'(req_item.var_slot) < ROOT_SLOTS) begin
          priority if (req_item.root_is_null) begin
            root_clr = load_fire;
          end else if (!tgt_ok) begin
            load_rsp.status = msr_pkg::ST_NOT_ALLOC;
          end else begin
            root_set = load_fire;
          end
        end
      end
      msr_pkg::REQ_ADD_REF: begin
        priority if (!src_ok || !tgt_ok) begin
          load_rsp.status = msr_pkg::ST_NOT_ALLOC;
        end else if (32'(src_refs) >= REFS_PER_CHUNK) begin
          load_rsp.status = msr_pkg::ST_REFS_FULL;
        end else begin
          ref_we = load_fire;
        end
      end
      default: begin
        load_rsp = '0;
      end
    endcase
  end

  assign root_we = root_set;

  // push candidate comes from a root target or a fetched reference
  always_comb begin
    push_cand = (state == S_RPUSH) ? root_rd : ref_rd;
    push_ok   = 1'b0;
    if (state == S_RPUSH) begin
      push_ok = root_has_q && (32'(root_rd) < 32'(chunk_count)) && !mark[root_rd];
    end else if (state == S_EPUSH) begin
      push_ok = (32'(ref_rd) < 32'(chunk_count)) && !mark[ref_rd];
    end
  end

  assign stk_ctrl.push = push_ok;
  assign stk_ctrl.pop  = (state == S_POP) && !stk_empty;

  assign rep_emit = (state == S_REPORT) && (!out_valid || rsp_ready);
  assign rep_last = (32'(rep_idx) + 1) == 32'(chunk_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunk_count <= '0;
      root_has    <= '0;
      mark        <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < HEAP_CHUNKS; i++) begin
        ref_count[i] <= '0;
      end
    end else begin
      if (push_ok) begin
        mark[push_cand] <= 1'b1;
      end
      if (alloc_do) begin
        ref_count[chunk_count[IDX_W-1:0]] <= '0;
        chunk_count                       <= chunk_count + CNT_W'(1);
      end
      if (root_set) begin
        root_has[slot_idx] <= 1'b1;
      end
      if (root_clr) begin
        root_has[slot_idx] <= 1'b0;
      end
      if (ref_we) begin
        ref_count[src_idx] <= src_refs + RC_W'(1);
      end

      if (load_fire || rep_emit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (collect_go) begin
            mark     <= '0;
            root_idx <= '0;
            state    <= S_RREAD;
          end
        end
        S_RREAD: begin
          root_has_q <= root_has[root_idx];
          state      <= S_RPUSH;
        end
        S_RPUSH: begin
          if (root_idx == SL_W'(ROOT_SLOTS - 1)) begin
            state <= S_POP;
          end else begin
            root_idx <= root_idx + SL_W'(1);
            state    <= S_RREAD;
          end
        end
        S_POP: begin
          if (stk_empty) begin
            rep_idx <= '0;
            state   <= S_REPORT;
          end else begin
            state <= S_POPD;
          end
        end
        S_POPD: begin
          cur     <= pop_data;
          ref_n   <= ref_count[pop_data];
          ref_idx <= '0;
          state   <= S_EREAD;
        end
        S_EREAD: begin
          state <= (ref_idx == ref_n) ? S_POP : S_EPUSH;
        end
        S_EPUSH: begin
          ref_idx <= ref_idx + RC_W'(1);
          state   <= S_EREAD;
        end
        S_REPORT: begin
          if (rep_emit) begin
            rep_idx <= rep_idx + IDX_W'(1);
            if (rep_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_item <= load_rsp;
    end else if (rep_emit) begin
      out_item.status      <= msr_pkg::ST_OK;
      out_item.chunk_index <= 4'(rep_idx);
      out_item.reachable   <= mark[rep_idx];
      out_item.last        <= rep_last;
    end
  end

  // root target memory
  always_ff @(posedge clk) begin
    if (root_we) begin
      root_target[slot_idx] <= tgt_idx;
    end
    if (state == S_RREAD) begin
      root_rd <= root_target[root_idx];
    end
  end

  // reference table memory
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_table[ref_wa] <= tgt_idx;
    end
    if (state == S_EREAD) begin
      ref_rd <= ref_table[ref_ra];
    end
  end

  msr_walk_stack #(
    .DEPTH (HEAP_CHUNKS),
    .WIDTH (IDX_W)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_data (push_cand),
    .pop_data  (pop_data),
    .empty     (stk_empty)
  );

  assign rsp_valid = out_valid;
  assign rsp_item  = out_item;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (state == S_IDLE))
    else $error("request taken outside idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(chunk_count) <= HEAP_CHUNKS)
    else $error("chunk count past heap size");

  a_report_done: assert property (@(posedge clk) disable iff (rst)
    (rep_emit && rep_last) |=> (state == S_IDLE) && stk_empty)
    else $error("report ended without returning to idle");

endmodule

// ===== rtl/msr_walk_stack.sv =====
// Walk stack for the mark phase: one-port memory with a depth counter, registered pop data.
module msr_walk_stack #(
  parameter int DEPTH = msr_pkg::HEAP_CHUNKS_DEF,
  parameter int WIDTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  msr_pkg::stack_ctrl_t ctrl,
  input  logic [WIDTH-1:0]     push_data,
  output logic [WIDTH-1:0]     pop_data,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DW-1:0]    depth;
  logic [DW-1:0]    depth_dec;

  assign depth_dec = depth - DW'(1);
  assign empty     = (depth == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctrl.push) begin
      depth <= depth + DW'(1);
    end else if (ctrl.pop) begin
      depth <= depth_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[depth[AW-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      pop_data <= mem[depth_dec[AW-1:0]];
    end
  end

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("stack push and pop in the same cycle");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !empty)
    else $error("stack pop while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> (32'(depth) < DEPTH))
    else $error("stack push while full");

endmodule
